// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("check failed");
`define ASSERT_NEVER(lbl, expr) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  !(expr)) else $error("forbidden condition");
`else
`define ASSERT_AT(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// ----- hw/rtl/ctbd_pkg.sv -----
// Types, constants and the prescaler shift table of the clock tree divisor.
`default_nettype none
package ctbd_pkg;
  localparam int OscW = 26;
  localparam int ClkW = 32;

  localparam logic [1:0] SRC_EXT = 2'd1;
  localparam logic [1:0] SRC_PLL = 2'd2;

  localparam logic REG_INT_OSC = 1'b0;
  localparam logic REG_EXT_OSC = 1'b1;

  localparam logic [31:0] RECIP3   = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP100 = 32'h51EB_851F;
  localparam logic [12:0] RECIP100_SMALL = 13'd5243;

  typedef struct packed {
    logic [23:0] baud_rate;
    logic        oversample_by_eight;
    logic        on_fast_bus;
    logic [2:0]  apb2_prescale_code;
    logic [2:0]  apb1_prescale_code;
    logic [3:0]  ahb_prescale_code;
    logic [1:0]  pll_p_code;
    logic [8:0]  pll_n;
    logic [5:0]  pll_m;
    logic        pll_from_external;
    logic [1:0]  clock_source;
  } item_t;

  typedef struct packed {
    logic [OscW-1:0] osc;
    logic [1:0]      src;
    logic            m_zero;
    logic [8:0]      n;
    logic [1:0]      pcode;
    logic [3:0]      ahb;
    logic [2:0]      apb1;
    logic [2:0]      apb2;
    logic            fast;
    logic            over8;
    logic [23:0]     baud;
  } ftag_t;

  typedef struct packed {
    logic [ClkW-1:0] sys;
    logic [ClkW-1:0] ahb;
    logic [ClkW-1:0] apb1;
    logic [ClkW-1:0] apb2;
    logic [ClkW-1:0] clk;
    logic            err;
    logic            over8;
    logic [23:0]     baud;
  } qent_t;

  typedef struct packed {
    logic            err;
    logic            over8;
    logic [ClkW-1:0] sys;
    logic [ClkW-1:0] ahb;
    logic [ClkW-1:0] apb1;
    logic [ClkW-1:0] apb2;
  } btag_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [3:0] shift_of(input logic [3:0] code);
    logic [3:0] s;
    case (code)
      4'd4:    s = 4'd1;
      4'd5:    s = 4'd2;
      4'd6:    s = 4'd3;
      4'd7:    s = 4'd4;
      4'd8:    s = 4'd1;
      4'd9:    s = 4'd2;
      4'd10:   s = 4'd3;
      4'd11:   s = 4'd4;
      4'd12:   s = 4'd6;
      4'd13:   s = 4'd7;
      4'd14:   s = 4'd8;
      4'd15:   s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/ctbd_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module ctbd_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 26,
  parameter int TAG_W = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  valid_o,
  output logic [NUM_W-1:0]      quo_o,
  output logic [TAG_W-1:0]      tag_o
);
  logic             vld_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [TAG_W-1:0] tag_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             vld_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign quo_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = {rem_in, quo_in[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        quo_q[k] <= {quo_in[NUM_W-2:0], fits};
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = quo_q[NUM_W-1];
  assign tag_o   = tag_q[NUM_W-1];
endmodule
`default_nettype wire

// ----- hw/rtl/ctbd_front.sv -----
// Front part: accept items, work out system and bus clocks, push to the queue.
`default_nettype none
module ctbd_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire ctbd_pkg::item_t      item_i,
  input  wire logic [25:0]          int_osc_i,
  input  wire logic [25:0]          ext_osc_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output ctbd_pkg::qent_t           ent_o
);
  import ctbd_pkg::*;

  logic        adv;
  logic [25:0] base;
  ftag_t       tag_in;
  logic [5:0]  den_in;
  logic        dv_vld;
  logic [25:0] dv_quo;
  logic [$bits(ftag_t)-1:0] dv_tag;
  ftag_t       dv_t;
  logic [34:0] vco_full;

  logic        a_vld_q;
  logic [31:0] a_vco_q;
  ftag_t       a_tag_q;
  logic        b_vld_q;
  logic [31:0] b_vco_q;
  logic [63:0] b_p3_q;
  ftag_t       b_tag_q;
  logic        c_vld_q;
  qent_t       c_ent_q;

  logic [31:0] pll_out;
  logic [31:0] sys;
  logic [31:0] ahb;
  logic [31:0] apb1;
  logic [31:0] apb2;
  qent_t       c_ent_d;

  assign adv     = !c_vld_q || ready_i;
  assign ready_o = adv;

  assign base   = item_i.pll_from_external ? ext_osc_i : int_osc_i;
  assign den_in = (item_i.pll_m == 6'd0) ? 6'd1 : item_i.pll_m;

  always_comb begin
    tag_in        = '0;
    tag_in.osc    = (item_i.clock_source == SRC_EXT) ? ext_osc_i : int_osc_i;
    tag_in.src    = item_i.clock_source;
    tag_in.m_zero = item_i.pll_m == 6'd0;
    tag_in.n      = item_i.pll_n;
    tag_in.pcode  = item_i.pll_p_code;
    tag_in.ahb    = item_i.ahb_prescale_code;
    tag_in.apb1   = item_i.apb1_prescale_code;
    tag_in.apb2   = item_i.apb2_prescale_code;
    tag_in.fast   = item_i.on_fast_bus;
    tag_in.over8  = item_i.oversample_by_eight;
    tag_in.baud   = item_i.baud_rate;
  end

  ctbd_div #(
    .NUM_W(26),
    .DEN_W(6),
    .TAG_W($bits(ftag_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (valid_i),
    .num_i   (base),
    .den_i   (den_in),
    .tag_i   (tag_in),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .tag_o   (dv_tag)
  );

  assign dv_t     = ftag_t'(dv_tag);
  assign vco_full = {9'd0, dv_quo} * {26'd0, dv_t.n};

  always_comb begin
    case (b_tag_q.pcode)
      2'd0:    pll_out = b_vco_q >> 1;
      2'd1:    pll_out = b_vco_q >> 2;
      2'd2:    pll_out = {1'b0, b_p3_q[63:33]};
      default: pll_out = b_vco_q >> 3;
    endcase
    if (b_tag_q.src == SRC_PLL) begin
      sys = b_tag_q.m_zero ? 32'd0 : pll_out;
    end else begin
      sys = {6'd0, b_tag_q.osc};
    end
    ahb  = sys >> shift_of(b_tag_q.ahb);
    apb1 = ahb >> shift_of({1'b0, b_tag_q.apb1});
    apb2 = ahb >> shift_of({1'b0, b_tag_q.apb2});
    c_ent_d       = '0;
    c_ent_d.sys   = sys;
    c_ent_d.ahb   = ahb;
    c_ent_d.apb1  = apb1;
    c_ent_d.apb2  = apb2;
    c_ent_d.clk   = b_tag_q.fast ? apb2 : apb1;
    c_ent_d.err   = ((b_tag_q.src == SRC_PLL) && b_tag_q.m_zero) || (b_tag_q.baud == 24'd0);
    c_ent_d.over8 = b_tag_q.over8;
    c_ent_d.baud  = b_tag_q.baud;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= dv_vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_vco_q <= vco_full[31:0];
      a_tag_q <= dv_t;
      b_vco_q <= a_vco_q;
      b_p3_q  <= {32'd0, 1'b0, a_vco_q[31:1]} * {32'd0, RECIP3};
      b_tag_q <= a_tag_q;
      c_ent_q <= c_ent_d;
    end
  end

  assign valid_o = c_vld_q;
  assign ent_o   = c_ent_q;
endmodule
`default_nettype wire

// ----- hw/rtl/ctbd_queue.sv -----
// Short queue between the front and back parts.
`default_nettype none
module ctbd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_valid_i,
  output logic                 wr_ready_o,
  input  wire ctbd_pkg::qent_t wr_data_i,
  output logic                 rd_valid_o,
  input  wire logic            rd_ready_i,
  output ctbd_pkg::qent_t      rd_data_o,
  output ctbd_pkg::qstat_t     stat_o
);
  import ctbd_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  qent_t         mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready_o = cnt_q != CntW'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign stat_o.full  = !wr_ready_o;
  assign stat_o.empty = !rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ctbd_back.sv -----
// Back part: divide the bus clock by the baud rate and form the divisor word.
`default_nettype none
module ctbd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire ctbd_pkg::qent_t ent_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output logic [15:0]          divisor_o,
  output ctbd_pkg::btag_t      res_o
);
  import ctbd_pkg::*;

  logic        adv;
  logic [31:0] num_in;
  logic [25:0] den_in;
  btag_t       tag_in;
  logic        dv_vld;
  logic [31:0] dv_quo;
  logic [$bits(btag_t)-1:0] dv_tag;

  logic        s1_vld_q;
  logic [31:0] s1_h_q;
  logic [63:0] s1_p_q;
  btag_t       s1_tag_q;
  logic        s2_vld_q;
  logic [11:0] s2_mant_q;
  logic [10:0] s2_v_q;
  btag_t       s2_tag_q;
  logic        out_vld_q;
  logic [15:0] div_q;
  btag_t       res_q;

  logic [26:0] mant;
  logic [31:0] m100;
  logic [6:0]  rem;
  logic [10:0] v_d;
  logic [23:0] frac_p;
  logic [3:0]  frac;

  assign adv     = !out_vld_q || ready_i;
  assign ready_o = adv;

  assign num_in = {ent_i.clk[27:0], 4'd0} + {ent_i.clk[28:0], 3'd0} + ent_i.clk;
  always_comb begin
    if (ent_i.baud == 24'd0) begin
      den_in = 26'd1;
    end else if (ent_i.over8) begin
      den_in = {1'b0, ent_i.baud, 1'b0};
    end else begin
      den_in = {ent_i.baud, 2'b0};
    end
    tag_in       = '0;
    tag_in.err   = ent_i.err;
    tag_in.over8 = ent_i.over8;
    tag_in.sys   = ent_i.sys;
    tag_in.ahb   = ent_i.ahb;
    tag_in.apb1  = ent_i.apb1;
    tag_in.apb2  = ent_i.apb2;
  end

  ctbd_div #(
    .NUM_W(32),
    .DEN_W(26),
    .TAG_W($bits(btag_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (valid_i),
    .num_i   (num_in),
    .den_i   (den_in),
    .tag_i   (tag_in),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .tag_o   (dv_tag)
  );

  assign mant = s1_p_q[63:37];
  assign m100 = 32'({5'd0, mant, 6'd0} + {6'd0, mant, 5'd0} + {9'd0, mant, 2'd0});
  assign rem  = 7'(s1_h_q - m100);
  assign v_d  = s1_tag_q.over8 ? ({1'b0, rem, 3'd0} + 11'd50) : ({rem, 4'd0} + 11'd50);
  assign frac_p = {13'd0, s2_v_q} * {11'd0, RECIP100_SMALL};
  assign frac   = s2_tag_q.over8 ? {1'b0, frac_p[21:19]} : frac_p[22:19];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= dv_vld;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_h_q    <= dv_quo;
      s1_p_q    <= {32'd0, dv_quo} * {32'd0, RECIP100};
      s1_tag_q  <= btag_t'(dv_tag);
      s2_mant_q <= mant[11:0];
      s2_v_q    <= v_d;
      s2_tag_q  <= s1_tag_q;
      div_q     <= s2_tag_q.err ? 16'd0 : {s2_mant_q, frac};
      res_q     <= s2_tag_q;
    end
  end

  assign valid_o   = out_vld_q;
  assign divisor_o = div_q;
  assign res_o     = res_q;
endmodule
`default_nettype wire

// ----- hw/rtl/clock_tree_baud_divisor.sv -----
// Top level of the clock tree and fractional baud divisor block.
//
//   port group    dir  content
//   s_axis_*      in   one clock tree description and baud rate per beat
//   m_axis_*      out  divisor word, clocks and error flag per beat
//   APB           in   oscillator frequency registers
//
// One beat accepted per cycle while the front is not stalled; results keep their order.
// A beat passes through the front (26-stage M divider, PLL multiply, output
// divide, bus shifts), then the queue, then the back (32-stage baud divider,
// two reciprocal multiplies).
// The queue lets the front keep accepting while the output is held, until the queue fills.
// Reset clears all valid bits and sets the oscillators to 16 MHz and 25 MHz.
`default_nettype none
`include "assert_macros.svh"
module clock_tree_baud_divisor #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // clock_source, pll_from_external, pll_m, pll_n, pll_p_code, ahb_prescale_code,
  // apb1_prescale_code, apb2_prescale_code, on_fast_bus, oversample_by_eight, baud_rate
  input  wire logic [55:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // divisor_word, system_hz, ahb_hz, apb1_hz, apb2_hz, error_flag, zero fill
  output logic [151:0]      m_axis_tdata,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ctbd_pkg::*;

  logic [25:0] int_osc_q;
  logic [25:0] ext_osc_q;
  logic        f_valid;
  logic        q_wr_ready;
  qent_t       f_ent;
  logic        q_valid;
  logic        b_ready;
  qent_t       q_ent;
  qstat_t      q_stat;
  logic [15:0] divisor;
  btag_t       res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EXT_OSC) ? {6'd0, ext_osc_q} : {6'd0, int_osc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_osc_q <= 26'd16000000;
      ext_osc_q <= 26'd25000000;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_EXT_OSC) begin
        ext_osc_q <= pwdata[25:0];
      end else begin
        int_osc_q <= pwdata[25:0];
      end
    end
  end

  ctbd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (item_t'(s_axis_tdata)),
    .int_osc_i (int_osc_q),
    .ext_osc_i (ext_osc_q),
    .valid_o   (f_valid),
    .ready_i   (q_wr_ready),
    .ent_o     (f_ent)
  );

  ctbd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (q_wr_ready),
    .wr_data_i  (f_ent),
    .rd_valid_o (q_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (q_ent),
    .stat_o     (q_stat)
  );

  ctbd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .ready_o   (b_ready),
    .ent_i     (q_ent),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .divisor_o (divisor),
    .res_o     (res)
  );

  assign m_axis_tdata = {7'd0, res.err, res.apb2, res.apb1, res.ahb, res.sys, divisor};

  `ASSERT_AT(a_err_zero_div, m_axis_tvalid && res.err |-> divisor == 16'd0)
  `ASSERT_AT(a_ahb_le_sys, m_axis_tvalid |-> res.ahb <= res.sys && res.apb1 <= res.ahb)
  `ASSERT_NEVER(a_queue_stat, q_stat.full && q_stat.empty)
endmodule
`default_nettype wire
